/* sv/hns_pkg.sv */
// ----------------------------------------------------------------------------
// hns_pkg
// Shared widths, register codes and job/config types of the heightmap normal
// stencil core.
// ----------------------------------------------------------------------------
package hns_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int DIM_W       = 11;
	localparam int H_W         = 16;
	localparam int SP_W        = 16;
	localparam int NRM_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_FLD_W   = COL_W + ROW_W + 3 * NRM_W;
	localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	localparam logic [NRM_W-1:0] ONE_Q14 = NRM_W'(16384);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_X_SPACING   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Z_SPACING   = CFG_IDX_W'(3);

	// clamped grid size and spacings
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [SP_W-1:0]  x_spacing;
		logic [SP_W-1:0]  z_spacing;
	} hns_cfg_t;

	// one normal to compute: height differences along x and z, spacing doublers
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic signed [H_W:0] dx;
		logic signed [H_W:0] dz;
		logic              x_two;
		logic              z_two;
		logic              done;
		logic              last;
	} hns_job_t;

endpackage

/* sv/hns_ram.sv */
// ----------------------------------------------------------------------------
// hns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* sv/hns_front.sv */
// ----------------------------------------------------------------------------
// hns_front
// Accepts heights, walks the grid counters, reads the line buffers and queues
// up to three normal jobs per height.
// ----------------------------------------------------------------------------
module hns_front import hns_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  hns_cfg_t       cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [H_W-1:0] in_height,
	output logic           push,
	output hns_job_t       push_job,
	input  logic           full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_RD1  = 2'd1;
	localparam logic [1:0] F_RD2  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	function automatic logic signed [H_W:0] hdiff(input logic [H_W-1:0] a,
		input logic [H_W-1:0] b);
		hdiff = $signed({a[H_W-1], a}) - $signed({b[H_W-1], b});
	endfunction

	logic [1:0]       state_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [H_W-1:0]   left_q, cur1_q, cur2_q;
	logic [H_W-1:0]   h_s1, pc_s1, pd_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	hns_job_t         jobs_q [3];
	logic [2:0]       mask_q;

	logic             wrap_col, col_end, row_end, accept;
	logic [COL_W-1:0] col_n;
	logic [DIM_W-1:0] row_t, col_inc, row_inc;
	logic [ROW_W-1:0] row_n;
	logic [COL_W-1:0] prev_rd_addr;
	logic [H_W-1:0]   prev_rd, rbp_rd;
	logic             ram_wr;
	logic             at_left, col_lt, last_row, c_pos;
	logic [H_W-1:0]   pl, pr, pd, hl1;
	hns_job_t         job0, job1, job2;
	logic [2:0]       mask_d, mask_clr;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;

	// normalize counters left over from a larger grid
	always_comb begin
		wrap_col = {1'b0, col_q} >= cfg.width;
		col_n    = wrap_col ? '0 : col_q;
		row_t    = DIM_W'(row_q) + (wrap_col ? DIM_W'(1) : '0);
		row_n    = (row_t >= cfg.height) ? '0 : row_t[ROW_W-1:0];
		col_inc  = DIM_W'(col_n) + DIM_W'(1);
		row_inc  = DIM_W'(row_n) + DIM_W'(1);
		col_end  = col_inc >= cfg.width;
		row_end  = row_inc >= cfg.height;
	end

	assign prev_rd_addr = (state_q == F_IDLE) ? col_n : col_s1 + COL_W'(1);
	assign ram_wr       = (state_q == F_RD2);

	hns_ram #(.WIDTH(H_W), .DEPTH(MAX_WIDTH)) u_prev_row (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (col_s1),
		.wr_data (h_s1),
		.rd_addr (prev_rd_addr),
		.rd_data (prev_rd)
	);

	hns_ram #(.WIDTH(H_W), .DEPTH(MAX_WIDTH)) u_prev2_row (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (col_s1),
		.wr_data (pc_s1),
		.rd_addr (col_n),
		.rd_data (rbp_rd)
	);

	always_comb begin
		at_left  = (col_s1 == '0);
		col_lt   = DIM_W'(col_s1) < (cfg.width - DIM_W'(1));
		last_row = DIM_W'(row_s1) == (cfg.height - DIM_W'(1));
		c_pos    = col_s1 > COL_W'(1);

		pl  = at_left ? pc_s1 : left_q;
		pr  = col_lt ? prev_rd : pc_s1;
		pd  = (row_s1 > ROW_W'(1)) ? pd_s1 : pc_s1;
		hl1 = c_pos ? cur2_q : cur1_q;

		mask_d[0] = (row_s1 != '0);
		mask_d[1] = last_row && !at_left;
		mask_d[2] = last_row && !col_lt;

		// normal of the vertex one row down
		job0.col   = col_s1;
		job0.row   = row_s1 - ROW_W'(1);
		job0.dx    = hdiff(pl, pr);
		job0.dz    = hdiff(h_s1, pd);
		job0.x_two = !at_left && col_lt;
		job0.z_two = row_s1 > ROW_W'(1);
		job0.done  = 1'b0;
		job0.last  = !mask_d[1] && !mask_d[2];

		// top row: normal of the vertex to the left
		job1.col   = col_s1 - COL_W'(1);
		job1.row   = row_s1;
		job1.dx    = hdiff(hl1, h_s1);
		job1.dz    = hdiff(cur1_q, left_q);
		job1.x_two = c_pos;
		job1.z_two = 1'b0;
		job1.done  = 1'b0;
		job1.last  = !mask_d[2];

		// final vertex of the grid
		job2.col   = col_s1;
		job2.row   = row_s1;
		job2.dx    = hdiff(cur1_q, h_s1);
		job2.dz    = hdiff(h_s1, pc_s1);
		job2.x_two = 1'b0;
		job2.z_two = 1'b0;
		job2.done  = 1'b1;
		job2.last  = 1'b1;
	end

	// push the lowest pending job
	always_comb begin
		mask_clr = 3'b000;
		push_job = jobs_q[2];
		if (mask_q[0]) begin
			push_job = jobs_q[0];
			mask_clr = 3'b001;
		end else if (mask_q[1]) begin
			push_job = jobs_q[1];
			mask_clr = 3'b010;
		end else begin
			mask_clr = 3'b100;
		end
		push = (state_q == F_PUSH) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			mask_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						col_q   <= col_end ? '0 : col_inc[COL_W-1:0];
						row_q   <= col_end ? (row_end ? '0 : row_inc[ROW_W-1:0]) : row_n;
						state_q <= F_RD1;
					end
				end
				F_RD1: begin
					state_q <= F_RD2;
				end
				F_RD2: begin
					mask_q  <= mask_d;
					state_q <= (mask_d != '0) ? F_PUSH : F_IDLE;
				end
				F_PUSH: begin
					if (push) begin
						mask_q <= mask_q & ~mask_clr;
						if ((mask_q & ~mask_clr) == '0) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_s1   <= in_height;
			col_s1 <= col_n;
			row_s1 <= row_n;
		end
		if (state_q == F_RD1) begin
			pc_s1 <= prev_rd;
			pd_s1 <= rbp_rd;
		end
		if (state_q == F_RD2) begin
			jobs_q[0] <= job0;
			jobs_q[1] <= job1;
			jobs_q[2] <= job2;
			left_q    <= pc_s1;
			cur2_q    <= cur1_q;
			cur1_q    <= h_s1;
		end
	end

`ifndef SYNTH
	a_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 ram_wr)
		else $error("line buffers not written two cycles after a height");
`endif

endmodule

/* sv/hns_queue.sv */
// ----------------------------------------------------------------------------
// hns_queue
// Short job queue between the stencil front and the normalizer.
// ----------------------------------------------------------------------------
module hns_queue import hns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hns_job_t push_job,
	output logic     full,
	input  logic     pop,
	output hns_job_t pop_job,
	output logic     empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	hns_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");
`endif

endmodule

/* sv/hns_back.sv */
// ----------------------------------------------------------------------------
// hns_back
// Normalizer: forms the cross product, scales it, takes the integer root of
// its squared length and divides each component, one bit per cycle.
// ----------------------------------------------------------------------------
module hns_back import hns_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  hns_cfg_t         cfg,
	input  logic             empty,
	input  hns_job_t         pop_job,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [COL_W-1:0] out_col,
	output logic [ROW_W-1:0] out_row,
	output logic [NRM_W-1:0] out_nx,
	output logic [NRM_W-1:0] out_ny,
	output logic [NRM_W-1:0] out_nz,
	output logic             out_last,
	output logic             out_done
);

	localparam int SPAN_W = SP_W + 1;
	localparam int PROD_W = SPAN_W + H_W + 2;
	localparam int MAG_W  = 2 * SPAN_W;
	localparam int M_W    = 31;
	localparam int SUM_W  = 64;
	localparam int LEN_W  = SUM_W / 2;
	localparam int NUM_W  = M_W + 15 + 1;
	localparam int DVS_W  = LEN_W + 1;
	localparam int SH_W   = $clog2(MAG_W - M_W + 1);
	localparam int K_W    = $clog2(LEN_W);
	localparam int STEP_W = $clog2(NRM_W + 1);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_NORM = 3'd2;
	localparam logic [2:0] B_SQ   = 3'd3;
	localparam logic [2:0] B_SQRT = 3'd4;
	localparam logic [2:0] B_DIV  = 3'd5;
	localparam logic [2:0] B_OUT  = 3'd6;

	logic [2:0]        state_q;
	hns_job_t          job_q;
	logic [SPAN_W-1:0] dxw_q, dzw_q;
	logic [MAG_W-1:0]  mag_q [3];
	logic [2:0]        neg_q;
	logic [M_W-1:0]    m_q [3];
	logic [SUM_W-1:0]  sum_q, vrem_q, res_q;
	logic [K_W-1:0]    k_q;
	logic [1:0]        idx_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  rem_q;
	logic [NRM_W-1:0]  nlow_q, q_q;
	logic [NRM_W-1:0]  nrm_q [3];
	logic              out_valid_q;

	logic signed [PROD_W-1:0] prod0, prod2;
	logic [MAG_W-1:0]         prod1, abs0, abs2, mx;
	logic [SH_W-1:0]          sh;
	logic [2*M_W-1:0]         sq;
	logic [SUM_W-1:0]         sum_next, bitv, trial;
	logic [LEN_W-1:0]         len;
	logic [DVS_W-1:0]         dvs;
	logic [NUM_W-1:0]         num;
	logic [DVS_W:0]           t;
	logic [NRM_W-1:0]         q_next;
	logic                     fire;

	assign pop       = (state_q == B_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign fire      = (state_q == B_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		prod0 = $signed({1'b0, dzw_q}) * $signed(job_q.dx);
		prod2 = $signed({1'b0, dxw_q}) * $signed(job_q.dz);
		prod1 = MAG_W'(dzw_q) * MAG_W'(dxw_q);
		abs0  = prod0[PROD_W-1] ? MAG_W'(-prod0) : MAG_W'(prod0);
		abs2  = prod2[PROD_W-1] ? MAG_W'(-prod2) : MAG_W'(prod2);

		mx = mag_q[0];
		if (mag_q[1] > mx) begin
			mx = mag_q[1];
		end
		if (mag_q[2] > mx) begin
			mx = mag_q[2];
		end
		// smallest shift bringing the largest magnitude under 2^31
		sh = '0;
		for (int i = 0; i < MAG_W - M_W; i++) begin
			if (mx[M_W + i]) begin
				sh = SH_W'(i + 1);
			end
		end

		sq       = (2*M_W)'(m_q[idx_q]) * (2*M_W)'(m_q[idx_q]);
		sum_next = sum_q + SUM_W'(sq);

		bitv  = SUM_W'(1) << {k_q, 1'b0};
		trial = res_q + bitv;

		len    = res_q[LEN_W-1:0];
		dvs    = {len, 1'b0};
		num    = NUM_W'({m_q[idx_q], 15'b0}) + NUM_W'(len);
		t      = {rem_q, nlow_q[NRM_W-1]};
		q_next = {q_q[NRM_W-2:0], (t >= {1'b0, dvs})};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_MUL;
					end
				end
				B_MUL:  state_q <= B_NORM;
				B_NORM: state_q <= B_SQ;
				B_SQ: begin
					if (idx_q == 2'd2) begin
						state_q <= (sum_next == '0) ? B_OUT : B_SQRT;
					end
				end
				B_SQRT: begin
					if (k_q == '0) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (step_q == STEP_W'(NRM_W) && idx_q == 2'd2) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (fire) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q <= pop_job;
				dxw_q <= pop_job.x_two ? {cfg.x_spacing, 1'b0} : {1'b0, cfg.x_spacing};
				dzw_q <= pop_job.z_two ? {cfg.z_spacing, 1'b0} : {1'b0, cfg.z_spacing};
			end
			B_MUL: begin
				mag_q[0] <= abs0;
				mag_q[1] <= prod1;
				mag_q[2] <= abs2;
				neg_q    <= {prod2[PROD_W-1], 1'b0, prod0[PROD_W-1]};
			end
			B_NORM: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= M_W'(mag_q[i] >> sh);
				end
				sum_q <= '0;
				idx_q <= '0;
			end
			B_SQ: begin
				sum_q  <= sum_next;
				vrem_q <= sum_next;
				res_q  <= '0;
				k_q    <= K_W'(LEN_W - 1);
				if (idx_q == 2'd2) begin
					idx_q    <= '0;
					step_q   <= '0;
					nrm_q[0] <= '0;
					nrm_q[1] <= ONE_Q14;
					nrm_q[2] <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			B_SQRT: begin
				if (vrem_q >= trial) begin
					vrem_q <= vrem_q - trial;
					res_q  <= (res_q >> 1) + bitv;
				end else begin
					res_q  <= res_q >> 1;
				end
				k_q <= k_q - K_W'(1);
			end
			B_DIV: begin
				if (step_q == '0) begin
					rem_q  <= DVS_W'(num[NUM_W-1:NRM_W]);
					nlow_q <= num[NRM_W-1:0];
					q_q    <= '0;
					step_q <= STEP_W'(1);
				end else begin
					rem_q  <= q_next[0] ? DVS_W'(t - {1'b0, dvs}) : t[DVS_W-1:0];
					nlow_q <= {nlow_q[NRM_W-2:0], 1'b0};
					q_q    <= q_next;
					if (step_q == STEP_W'(NRM_W)) begin
						nrm_q[idx_q] <= neg_q[idx_q] ? NRM_W'(0) - q_next : q_next;
						idx_q        <= idx_q + 2'd1;
						step_q       <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
			end
			B_OUT: begin
				if (fire) begin
					out_col  <= job_q.col;
					out_row  <= job_q.row;
					out_nx   <= nrm_q[0];
					out_ny   <= nrm_q[1];
					out_nz   <= nrm_q[2];
					out_last <= job_q.last;
					out_done <= job_q.done;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (len != '0))
		else $error("normalizer divides by a zero length");
	a_sqrt_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SQ && idx_q == 2'd2 && sum_next != '0) |=> (state_q == B_SQRT))
		else $error("nonzero vector skipped the square root");
`endif

endmodule

/* sv/heightmap_normal_stencil_core.sv */
// Flow: a height is taken in F_IDLE, the line buffers are read through F_RD1 and F_RD2,
// and the height's jobs are pushed in F_PUSH, which waits while the queue is full.
// Up to three normals per height, each 32 root and 3 x 17 divide steps in the normalizer.
// The normalizer's bit-serial root and divide set the rate; the front waits on the queue.
// Reset: arst_n clears counters, queue and output valid; line buffers are not cleared.
// ----------------------------------------------------------------------------
// heightmap_normal_stencil_core
// Streams grid heights through two line buffers and emits Q1.14 vertex
// normals by central differences, one row behind, flushing the top row.
// ----------------------------------------------------------------------------
module heightmap_normal_stencil_core import hns_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [H_W-1:0]         s_axis_tdata,   // [15:0] height
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // column, row, normal_x/y/z, zero pad
	output logic                   m_axis_tlast,   // run_last
	output logic                   m_axis_tuser,   // grid_done
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// raw configuration registers
	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [SP_W-1:0]  x_spacing_q, z_spacing_q;
	hns_cfg_t         cfg;

	hns_job_t         push_job, pop_job;
	logic             push, pop, full, empty;

	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic [NRM_W-1:0] out_nx, out_ny, out_nz;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_W'(2);
			grid_height_q <= DIM_W'(2);
			x_spacing_q   <= SP_W'(256);
			z_spacing_q   <= SP_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				REG_X_SPACING:   x_spacing_q   <= cfg_data[SP_W-1:0];
				REG_Z_SPACING:   z_spacing_q   <= cfg_data[SP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp the grid size to what the line buffers hold
	always_comb begin
		cfg.width = (grid_width_q < DIM_W'(2)) ? DIM_W'(2) :
			(grid_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_q;
		cfg.height = (grid_height_q < DIM_W'(2)) ? DIM_W'(2) :
			(grid_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height_q;
		cfg.x_spacing = x_spacing_q;
		cfg.z_spacing = z_spacing_q;
	end

	// front: take a request, read neighbors, queue normal jobs
	hns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_height (s_axis_tdata),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	// decouple stencil and normalizer
	hns_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// back: normalize and hold the result in the output register
	hns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_col   (out_col),
		.out_row   (out_row),
		.out_nx    (out_nx),
		.out_ny    (out_ny),
		.out_nz    (out_nz),
		.out_last  (m_axis_tlast),
		.out_done  (m_axis_tuser)
	);

	// pack result fields from the low bit up, zero pad to whole bytes
	assign m_axis_tdata = OUT_TDATA_W'({out_nz, out_ny, out_nx, out_row, out_col});

endmodule

/* tb/heightmap_normal_stencil_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_normal_stencil_core_tb
// Streams whole height grids through the core under several grid sizes and
// spacings, predicts every vertex normal in the bench and checks each result
// request field by field, in order, with random idling on both streams.
// ----------------------------------------------------------------------------
module heightmap_normal_stencil_core_tb;
	import hns_pkg::*;

	// one expected normal
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
		logic [NRM_W-1:0] nz;
		logic             last;
		logic             done;
	} normal_t;

	localparam int IDLE_LIMIT = 10000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [H_W-1:0]         s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// bench-side copy of the core state
	logic signed [H_W-1:0] line_prev [MAX_WIDTH];
	logic signed [H_W-1:0] line_prev2 [MAX_WIDTH];
	int unsigned           col_cnt, row_cnt;
	logic signed [H_W-1:0] left_h;
	int unsigned           width_reg, height_reg, xsp_reg, zsp_reg;

	logic [H_W-1:0] heights_pending [$];
	normal_t        normals_due [$];
	int             errors;
	int             idle_cycles;
	int             items_sent;
	bit             quiet;

	heightmap_normal_stencil_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Scale (Dz*(hl-hr), Dz*Dx, Dx*(hu-hd)) to unit length in Q1.14.
	function automatic normal_t unit_normal(int unsigned c, int unsigned r,
			int hl, int hr, int hd, int hu, int unsigned cx, int unsigned cz, bit done);
		longint          dxw, dzw;
		longint          v [3];
		longint unsigned m [3];
		longint unsigned mx, sum, len, q;
		logic [NRM_W-1:0] comp [3];
		int              s;
		normal_t         n;
		dxw = longint'(cx) * longint'(xsp_reg);
		dzw = longint'(cz) * longint'(zsp_reg);
		v[0] = dzw * longint'(hl - hr);
		v[1] = dzw * dxw;
		v[2] = dxw * longint'(hu - hd);
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
			if (m[i] > mx) mx = m[i];
		end
		s = 0;
		while ((mx >> s) >= (64'd1 << 31)) s++;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= s;
			sum += m[i] * m[i];
		end
		if (sum == 0) begin
			comp[0] = '0;
			comp[1] = ONE_Q14;
			comp[2] = '0;
		end else begin
			len = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = (m[i] * 32768 + len) / (2 * len);
				if (v[i] < 0) q = -q;
				comp[i] = q[NRM_W-1:0];
			end
		end
		n.col  = c[COL_W-1:0];
		n.row  = r[ROW_W-1:0];
		n.nx   = comp[0];
		n.ny   = comp[1];
		n.nz   = comp[2];
		n.last = 1'b0;
		n.done = done;
		return n;
	endfunction

	// Advance the stencil by one height and queue the normals it completes.
	task automatic take_height(logic [H_W-1:0] raw);
		int unsigned w, hg, c, r, cx, cz, lc;
		int          h, pc, pl, pr, pd, ctr, lf;
		logic signed [H_W-1:0] old;
		normal_t     made [$];
		normal_t     n;
		w  = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		hg = height_reg < 2 ? 2 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		c  = col_cnt;
		r  = row_cnt;
		h  = $signed(raw);
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= hg) r = 0;
		if (r >= 1) begin
			pc = line_prev[c];
			pl = c > 0 ? int'(left_h) : pc;
			pr = c < w - 1 ? int'(line_prev[c + 1]) : pc;
			pd = r > 1 ? int'(line_prev2[c]) : pc;
			cx = (c > 0 ? 1 : 0) + (c < w - 1 ? 1 : 0);
			cz = 1 + (r > 1 ? 1 : 0);
			made.insert(made.size(), unit_normal(c, r - 1, pl, pr, pd, h, cx, cz, 1'b0));
		end
		old = line_prev[c];
		line_prev2[c] = old;
		line_prev[c] = raw;
		left_h = old;
		// top row: flush the vertex to the left, and the corner at the end
		if (r == hg - 1 && c >= 1) begin
			lc  = c - 1;
			ctr = line_prev[lc];
			lf  = lc > 0 ? int'(line_prev[lc - 1]) : ctr;
			cx  = (lc > 0 ? 1 : 0) + 1;
			made.insert(made.size(), unit_normal(lc, r, lf, h, line_prev2[lc], ctr, cx, 1,
				1'b0));
		end
		if (r == hg - 1 && c == w - 1)
			made.insert(made.size(), unit_normal(c, r, line_prev[c - 1], h, line_prev2[c],
				h, 1, 1, 1'b1));
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= hg) r = 0;
		end
		col_cnt = c;
		row_cnt = r;
		if (made.size() > 0) made[made.size() - 1].last = 1'b1;
		foreach (made[i]) normals_due.insert(normals_due.size(), made[i]);
	endtask

	// Driver: hold a request until taken, then advance from the pending queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) take_height(s_axis_tdata);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold
			end else if (heights_pending.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
				s_axis_tdata  <= heights_pending.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result request with the oldest expected normal.
	always @(posedge clk or negedge arst_n) begin
		normal_t want, got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.col  = m_axis_tdata[COL_W-1:0];
				got.row  = m_axis_tdata[COL_W +: ROW_W];
				got.nx   = m_axis_tdata[COL_W + ROW_W +: NRM_W];
				got.ny   = m_axis_tdata[COL_W + ROW_W + NRM_W +: NRM_W];
				got.nz   = m_axis_tdata[COL_W + ROW_W + 2 * NRM_W +: NRM_W];
				got.last = m_axis_tlast;
				got.done = m_axis_tuser;
				if (normals_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected normal expected none actual col=%0d row=%0d",
						$time, got.col, got.row);
				end else begin
					want = normals_due.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: normal mismatch expected col=%0d row=%0d n=(%0d,%0d,%0d)",
							$time, want.col, want.row, $signed(want.nx), $signed(want.ny),
							$signed(want.nz), " last=%0b done=%0b", want.last, want.done,
							" actual col=%0d row=%0d n=(%0d,%0d,%0d)", got.col, got.row,
							$signed(got.nx), $signed(got.ny), $signed(got.nz),
							" last=%0b done=%0b", got.last, got.done);
					end
				end
			end
			m_axis_tready <= quiet || $urandom_range(99) >= 12;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** heightmap_normal_stencil_core: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:  width_reg  = value & 32'h7FF;
			REG_GRID_HEIGHT: height_reg = value & 32'h7FF;
			REG_X_SPACING:   xsp_reg    = value & 32'hFFFF;
			REG_Z_SPACING:   zsp_reg    = value & 32'hFFFF;
			default: begin
			end
		endcase
	endtask

	task automatic set_grid(int unsigned w, int unsigned hg, int unsigned xs, int unsigned zs);
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, hg);
		write_reg(REG_X_SPACING, xs);
		write_reg(REG_Z_SPACING, zs);
	endtask

	// Wait for the sender to drain and every expected normal to arrive.
	task automatic drain();
		while (heights_pending.size() > 0 || s_axis_tvalid || normals_due.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [H_W-1:0] pick_height();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned grid_size();
		int unsigned w, hg;
		w  = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		hg = height_reg < 2 ? 2 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		return w * hg;
	endfunction

	task automatic queue_grid(bit pause_mid);
		int unsigned n;
		n = grid_size();
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) drain();
			heights_pending.insert(heights_pending.size(), pick_height());
		end
		items_sent += n;
	endtask

	initial begin
		logic [H_W-1:0] corner [4];
		errors        = 0;
		items_sent    = 0;
		quiet         = 1'b0;
		idle_cycles   = 0;
		col_cnt       = 0;
		row_cnt       = 0;
		left_h        = '0;
		width_reg     = 2;
		height_reg    = 2;
		xsp_reg       = 256;
		zsp_reg       = 256;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, height extremes on a 2x2 grid
		corner = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
		foreach (corner[i]) heights_pending.insert(heights_pending.size(), corner[i]);
		items_sent += 4;
		drain();
		// 3x3, widest spacing against narrowest
		set_grid(3, 3, 65535, 1);
		for (int i = 0; i < 9; i++)
			heights_pending.insert(heights_pending.size(), i % 2 ? 16'h7FFF : 16'h8000);
		items_sent += 9;
		drain();
		// zero x spacing leaves only the x component, or the zero vector
		set_grid(2, 2, 0, 256);
		for (int i = 0; i < 4; i++)
			heights_pending.insert(heights_pending.size(), 16'($urandom));
		items_sent += 4;
		drain();
		// width and height below two clamp up to two
		set_grid(1, 0, 1, 1);
		queue_grid(1'b0);
		drain();
		set_grid(0, 3, 65535, 65535);
		queue_grid(1'b0);
		drain();

		// random grids; the first one runs with no idling, one pauses midway
		for (int k = 0; items_sent < 220; k++) begin
			quiet = (k == 0);
			set_grid($urandom_range(8, 2), $urandom_range(5, 2), $urandom_range(65535),
				$urandom_range(65535));
			queue_grid(k == 2);
			drain();
		end
		quiet = 1'b0;
		repeat (100) @(posedge clk);

		if (errors == 0) begin
			$display("** heightmap_normal_stencil_core: PASSED **");
		end else begin
			$display("** heightmap_normal_stencil_core: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
sv/hns_pkg.sv
sv/hns_ram.sv
sv/hns_front.sv
sv/hns_queue.sv
sv/hns_back.sv
sv/heightmap_normal_stencil_core.sv
tb/heightmap_normal_stencil_core_tb.sv
